// ----- sv/hftw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tree-walk decoder package
// Widths, field codes, the sequencer state type and the root index function
// shared by the decoder and its tables.
// ----------------------------------------------------------------------------
package hftw_pkg;

	localparam int MAX_SYMBOLS = 256;
	localparam int NODE_SLOTS  = 511;
	localparam int NODE_W      = 9;
	localparam int SYM_W       = 8;
	localparam int LEAF_ADDR_W = $clog2(MAX_SYMBOLS);
	localparam int CNT_W       = 4;
	localparam int PAD_W       = 3;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 9;

	localparam int IN_FIELDS_W = 2 * NODE_W + 1 + 2 * SYM_W;
	localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = SYM_W;

	localparam logic [NODE_W-1:0] NODE_NONE = NODE_W'(NODE_SLOTS);

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_DATA = 1'b1;

	localparam logic SIDE_LEFT  = 1'b0;
	localparam logic SIDE_RIGHT = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_LEAF_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_BITS   = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_FETCH = 5'b00010,
		ST_WALK  = 5'b00100,
		ST_LEAF  = 5'b01000,
		ST_DRAIN = 5'b10000
	} state_t;

	// Clamps a written leaf count into the range one to MAX_SYMBOLS.
	function automatic logic [NODE_W-1:0] clamp_leaves(input logic [CFG_DATA_W-1:0] value);
		logic [NODE_W-1:0] n;
		n = NODE_W'(value);
		if (n == '0) begin
			n = NODE_W'(1);
		end else if (n > NODE_W'(MAX_SYMBOLS)) begin
			n = NODE_W'(MAX_SYMBOLS);
		end
		return n;
	endfunction

	function automatic logic [NODE_W-1:0] root_of(input logic [NODE_W-1:0] leaves);
		logic [NODE_W:0] twice;
		twice = {leaves, 1'b0} - (NODE_W + 1)'(2);
		return twice[NODE_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ----- sv/hftw_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module hftw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire                      re,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- sv/huffman_tree_walk_decoder_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tree-walk decoder
// Loads a code tree one node at a time and decodes packed bytes against it.
// ----------------------------------------------------------------------------
//  Channel   Dir  Contents
//  s_*       in   tuser: op; tlast: final_byte; tdata: node, parent, side, symbols
//  m_*       out  tdata: symbol; tlast: last symbol of the word's byte
//  cfg_*     in   register writes: 0 leaf_count, 1 pad_bits
//
//  A load word is taken in the idle state. A data word is accepted, the
//  first child is read, one coded bit at a time walks the shared child
//  tables with a leaf-table state per decoded symbol, and a drain state
//  finishes; with a one-leaf tree the walk is skipped. The dependent child
//  read sets the one-bit-per-cycle pace, apart from leaf states and output
//  stalls. The decoder stalls when the output word is not taken. After
//  reset the walk sits at the root of a 256-leaf tree; the tables are unset.
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder_top (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	// node_index, parent_index, child_side, leaf_symbol, data_byte, zero fill
	input  wire  [hftw_pkg::IN_TDATA_W-1:0]      s_tdata,
	// op
	input  wire                                  s_tuser,
	input  wire                                  s_tlast,
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	// symbol
	output logic [hftw_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic                                 m_tlast,
	input  wire                                  cfg_we,
	input  wire  [hftw_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [hftw_pkg::CFG_DATA_W-1:0]      cfg_data
);

	import hftw_pkg::*;

	state_t               state_q, state_d;
	logic [NODE_W-1:0]    leaves_q, root_q, walk_q, walk_d;
	logic [PAD_W-1:0]     pad_q;
	logic [SYM_W-1:0]     byte_q, byte_d;
	logic [CNT_W-1:0]     rem_q, rem_d;
	logic                 fin_q, fin_d;
	logic [SYM_W-1:0]     pend_q, pend_d;
	logic                 pend_v_q, pend_v_d;
	logic                 m_tvalid_q;
	logic [SYM_W-1:0]     m_sym_q;
	logic                 m_last_q;
	logic                 push;
	logic                 push_last;

	logic [NODE_W-1:0]    in_node, in_parent;
	logic                 in_side;
	logic [SYM_W-1:0]     in_sym, in_byte;
	logic                 accept, ld, dat;
	logic                 leaf_we, left_we, right_we;
	logic [CNT_W-1:0]     nbits;

	logic [NODE_W-1:0]    left_rd, right_rd, child, child_raddr;
	logic                 child_re, child_is_leaf, out_free, leaf_re;
	logic [SYM_W-1:0]     leaf_rd;
	logic [NODE_W-1:0]    new_leaves;

	assign in_node   = s_tdata[NODE_W-1:0];
	assign in_parent = s_tdata[2*NODE_W-1:NODE_W];
	assign in_side   = s_tdata[2*NODE_W];
	assign in_sym    = s_tdata[2*NODE_W+SYM_W:2*NODE_W+1];
	assign in_byte   = s_tdata[2*NODE_W+2*SYM_W:2*NODE_W+SYM_W+1];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign ld       = accept && (s_tuser == OP_LOAD);
	assign dat      = accept && (s_tuser == OP_DATA);

	assign leaf_we  = ld && (in_node < leaves_q);
	assign left_we  = ld && (in_node != NODE_NONE) && (in_parent != NODE_NONE) &&
	                  (in_node != root_q) && (in_side == SIDE_LEFT);
	assign right_we = ld && (in_node != NODE_NONE) && (in_parent != NODE_NONE) &&
	                  (in_node != root_q) && (in_side == SIDE_RIGHT);

	assign nbits = s_tlast ? (CNT_W'(8) - CNT_W'(pad_q)) : CNT_W'(8);

	assign child         = byte_q[SYM_W-1] ? right_rd : left_rd;
	assign child_is_leaf = (child < leaves_q);
	assign child_re      = (state_q == ST_FETCH) || (state_q == ST_WALK);
	assign child_raddr   = (state_q == ST_WALK) ? (child_is_leaf ? root_q : child) : walk_q;
	assign leaf_re       = (state_q == ST_WALK) && child_is_leaf;
	assign out_free      = !m_tvalid_q || m_tready;
	assign new_leaves    = clamp_leaves(cfg_data);

	hftw_ram #(.WIDTH(NODE_W), .DEPTH(NODE_SLOTS)) u_left (
		.clk   (clk),
		.we    (left_we),
		.waddr (in_parent),
		.wdata (in_node),
		.re    (child_re),
		.raddr (child_raddr),
		.rdata (left_rd)
	);

	hftw_ram #(.WIDTH(NODE_W), .DEPTH(NODE_SLOTS)) u_right (
		.clk   (clk),
		.we    (right_we),
		.waddr (in_parent),
		.wdata (in_node),
		.re    (child_re),
		.raddr (child_raddr),
		.rdata (right_rd)
	);

	hftw_ram #(.WIDTH(SYM_W), .DEPTH(MAX_SYMBOLS)) u_leaf (
		.clk   (clk),
		.we    (leaf_we),
		.waddr (in_node[LEAF_ADDR_W-1:0]),
		.wdata (in_sym),
		.re    (leaf_re),
		.raddr (child[LEAF_ADDR_W-1:0]),
		.rdata (leaf_rd)
	);

	always_comb begin
		state_d   = state_q;
		walk_d    = walk_q;
		byte_d    = byte_q;
		rem_d     = rem_q;
		fin_d     = fin_q;
		pend_d    = pend_q;
		pend_v_d  = pend_v_q;
		push      = 1'b0;
		push_last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (dat) begin
					byte_d  = in_byte;
					rem_d   = nbits;
					fin_d   = s_tlast;
					state_d = ST_FETCH;
				end
				if (cfg_we && (cfg_index == REG_LEAF_COUNT)) begin
					walk_d = root_of(new_leaves);
				end
			end
			ST_FETCH: begin
				if (walk_q < leaves_q) begin
					state_d = ST_DRAIN;
				end else begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				byte_d = {byte_q[SYM_W-2:0], 1'b0};
				rem_d  = rem_q - CNT_W'(1);
				if (child_is_leaf) begin
					walk_d  = root_q;
					state_d = ST_LEAF;
				end else begin
					walk_d  = child;
					state_d = (rem_q == CNT_W'(1)) ? ST_DRAIN : ST_WALK;
				end
			end
			ST_LEAF: begin
				if (!pend_v_q || out_free) begin
					push     = pend_v_q;
					pend_d   = leaf_rd;
					pend_v_d = 1'b1;
					state_d  = (rem_q == '0) ? ST_DRAIN : ST_WALK;
				end
			end
			ST_DRAIN: begin
				if (!pend_v_q || out_free) begin
					push      = pend_v_q;
					push_last = 1'b1;
					pend_v_d  = 1'b0;
					if (fin_q) begin
						walk_d = root_q;
					end
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			leaves_q   <= NODE_W'(MAX_SYMBOLS);
			root_q     <= root_of(NODE_W'(MAX_SYMBOLS));
			walk_q     <= root_of(NODE_W'(MAX_SYMBOLS));
			pad_q      <= '0;
			pend_v_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			walk_q   <= walk_d;
			pend_v_q <= pend_v_d;
			if (cfg_we && (cfg_index == REG_LEAF_COUNT)) begin
				leaves_q <= new_leaves;
				root_q   <= root_of(new_leaves);
			end
			if (cfg_we && (cfg_index == REG_PAD_BITS)) begin
				pad_q <= cfg_data[PAD_W-1:0];
			end
			if (push) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		byte_q <= byte_d;
		rem_q  <= rem_d;
		fin_q  <= fin_d;
		pend_q <= pend_d;
		if (push) begin
			m_sym_q  <= pend_q;
			m_last_q <= push_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_sym_q;
	assign m_tlast  = m_last_q;

endmodule
`default_nettype wire

// ----- verif/tb_huffman_tree_walk_decoder_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tree-walk decoder testbench
// Loads random code trees over a subset of the leaves for many leaf counts,
// decodes random bytes against them and checks every symbol word and its
// last flag against a predictor that walks its own copy of the tree. Loads
// that rewire the tree are mixed in, but never in a way that leads a walk to
// an unloaded node. Both handshakes idle at random, with one long receiver
// hold-off and one sender pause until every outstanding symbol has arrived.
// ----------------------------------------------------------------------------
module tb_huffman_tree_walk_decoder_top;
	import hftw_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 400;
	localparam int TREE_LEAVES = 12;
	localparam int PHASE_WORDS = 20;

	typedef struct packed {
		bit          op;
		bit [8:0]    node;
		bit [8:0]    parent;
		bit          side;
		bit [7:0]    sym;
		bit [7:0]    data;
		bit          fin;
	} in_word_t;

	typedef struct {
		bit [7:0] symbol;
		bit       is_last;
	} symbol_word_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   s_tuser = 1'b0;
	logic                   s_tlast = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	huffman_tree_walk_decoder_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	bit [8:0] tree_left [NODE_SLOTS];
	bit [8:0] tree_right [NODE_SLOTS];
	bit [7:0] leaf_sym [MAX_SYMBOLS];
	bit [8:0] walk_node = 9'(2 * MAX_SYMBOLS - 2);
	bit [8:0] leaf_count_reg = 9'(MAX_SYMBOLS);
	bit [2:0] pad_reg = '0;

	in_word_t     words_to_send[$];
	symbol_word_t symbols_due[$];
	int           live_nodes[$];
	in_word_t     on_offer;
	bit           word_taken = 1'b0;
	int           n_queued = 0;
	int           n_accepted = 0;
	int           n_errors = 0;
	int           cycle_count = 0;
	int           src_idle_pct = 0;
	int           sink_stall_pct = 0;
	int           hold_left = 0;
	bit           hold_wanted = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int eff_leaves(bit [8:0] value);
		if (value == 0)
			return 1;
		if (value > MAX_SYMBOLS)
			return MAX_SYMBOLS;
		return int'(value);
	endfunction

	function automatic bit [8:0] root_for(int leaves);
		return 9'(2 * leaves - 2);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (n_errors < 100)
			$display("mismatch at cycle %0d: %s, got %0d, expected %0d",
				cycle_count, what, got, want);
		n_errors++;
	endtask

	function automatic void decode_word(in_word_t w);
		int           leaves;
		int           nbits;
		int           count;
		bit [8:0]     root;
		bit [8:0]     cur;
		bit [8:0]     nxt;
		symbol_word_t item;
		leaves = eff_leaves(leaf_count_reg);
		root = root_for(leaves);
		if (w.op == OP_LOAD) begin
			if (w.node < leaves)
				leaf_sym[w.node[7:0]] = w.sym;
			if (w.node != NODE_NONE && w.parent != NODE_NONE && w.node != root) begin
				if (w.side == SIDE_LEFT)
					tree_left[w.parent] = w.node;
				else
					tree_right[w.parent] = w.node;
			end
			return;
		end
		nbits = w.fin ? 8 - int'(pad_reg) : 8;
		count = 0;
		for (int i = 0; i < nbits; i++) begin
			cur = walk_node;
			if (cur >= NODE_SLOTS)
				cur = root;
			if (cur < leaves) begin
				walk_node = root;
			end else begin
				nxt = w.data[7 - i] ? tree_right[cur] : tree_left[cur];
				if (nxt < leaves) begin
					item.symbol = leaf_sym[nxt[7:0]];
					item.is_last = 1'b0;
					symbols_due.push_back(item);
					count++;
					walk_node = root;
				end else begin
					walk_node = nxt;
				end
			end
		end
		if (count > 0)
			symbols_due[symbols_due.size() - 1].is_last = 1'b1;
		if (w.fin)
			walk_node = root;
	endfunction

	function automatic void push_load(int node, int parent, bit side, int sym);
		in_word_t w;
		w = '0;
		w.op = OP_LOAD;
		w.node = 9'(node);
		w.parent = 9'(parent);
		w.side = side;
		w.sym = 8'(sym);
		words_to_send.push_back(w);
		n_queued++;
	endfunction

	function automatic void push_data(int value, bit fin);
		in_word_t w;
		w = '0;
		w.op = OP_DATA;
		w.data = 8'(value);
		w.fin = fin;
		words_to_send.push_back(w);
		n_queued++;
	endfunction

	// Builds a full code tree over up to TREE_LEAVES randomly chosen leaves,
	// numbering the internal nodes so that the last one joined is the root.
	// The newest subtree is sometimes joined again so that long codes occur.
	function automatic void load_tree();
		int pool[$];
		int kids[2];
		int leaves;
		int n_leaves;
		int next_id;
		int pick;
		int cand;
		bit seen;
		leaves = eff_leaves(leaf_count_reg);
		live_nodes.delete();
		if (leaves == 1) begin
			live_nodes.push_back(0);
			push_load(0, $urandom_range(510), 1'($urandom_range(1)), $urandom_range(255));
			return;
		end
		n_leaves = (leaves < TREE_LEAVES) ? leaves : TREE_LEAVES;
		while (pool.size() < n_leaves) begin
			cand = $urandom_range(leaves - 1);
			seen = 1'b0;
			foreach (pool[k])
				if (pool[k] == cand)
					seen = 1'b1;
			if (!seen)
				pool.push_back(cand);
		end
		next_id = 2 * leaves - n_leaves;
		while (pool.size() > 1) begin
			for (int j = 0; j < 2; j++) begin
				pick = ($urandom_range(1) == 1) ? pool.size() - 1
					: $urandom_range(pool.size() - 1);
				kids[j] = pool[pick];
				pool.delete(pick);
			end
			push_load(kids[0], next_id, SIDE_LEFT, $urandom_range(255));
			push_load(kids[1], next_id, SIDE_RIGHT, $urandom_range(255));
			live_nodes.push_back(kids[0]);
			live_nodes.push_back(kids[1]);
			pool.push_back(next_id);
			next_id++;
		end
		live_nodes.push_back(int'(root_for(leaves)));
		push_load(int'(root_for(leaves)), $urandom_range(511), 1'($urandom_range(1)),
			$urandom_range(255));
	endfunction

	// A stray load may only link a node of the live tree, or touch a parent
	// that no walk of the live tree can reach.
	function automatic void noise_load();
		int leaves;
		int top;
		int node;
		int parent;
		leaves = eff_leaves(leaf_count_reg);
		top = 2 * leaves - 2;
		case ($urandom_range(3))
			0: begin
				node = NODE_NONE;
				parent = $urandom_range(511);
			end
			1: begin
				node = $urandom_range(511);
				parent = NODE_NONE;
			end
			2: begin
				node = live_nodes[$urandom_range(live_nodes.size() - 1)];
				parent = $urandom_range(511);
			end
			default: begin
				if (top < NODE_SLOTS - 1) begin
					node = $urandom_range(NODE_SLOTS - 1, top + 1);
					parent = ($urandom_range(1) == 1) ? $urandom_range(leaves - 1)
						: $urandom_range(511, top + 1);
				end else begin
					node = live_nodes[$urandom_range(live_nodes.size() - 1)];
					parent = $urandom_range(511);
				end
			end
		endcase
		push_load(node, parent, 1'($urandom_range(1)), $urandom_range(255));
	endfunction

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == REG_LEAF_COUNT) begin
			leaf_count_reg = value;
			walk_node = root_for(eff_leaves(value));
		end else begin
			pad_reg = value[2:0];
		end
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		while (n_accepted != n_queued || symbols_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic settle();
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_idling(input int p);
		case (p % 4)
			0: begin
				src_idle_pct = 0;
				sink_stall_pct = 0;
			end
			1: begin
				src_idle_pct = 56;
				sink_stall_pct = 0;
			end
			2: begin
				src_idle_pct = 0;
				sink_stall_pct = 56;
			end
			default: begin
				src_idle_pct = 12;
				sink_stall_pct = 12;
			end
		endcase
	endtask

	task automatic random_phase(input int p);
		int lc;
		case (p)
			0: lc = 511;
			1: lc = 1;
			7: lc = 300;
			default: lc = $urandom_range(16, 2);
		endcase
		set_idling(p);
		cfg_write(REG_LEAF_COUNT, 9'(lc));
		cfg_write(REG_PAD_BITS, 9'($urandom_range(7)));
		load_tree();
		if (p == 2)
			hold_wanted = 1'b1;
		for (int i = 0; i < PHASE_WORDS; i++) begin
			if (p == 3 && i == PHASE_WORDS / 2)
				drain();
			if ($urandom_range(99) < 80)
				push_data($urandom_range(255), $urandom_range(99) < 20);
			else
				noise_load();
		end
		settle();
	endtask

	always @(negedge clk) begin
		if (!s_tvalid || word_taken) begin
			word_taken = 1'b0;
			if (words_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				on_offer = words_to_send.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= on_offer.op;
				s_tlast <= on_offer.fin;
				s_tdata <= IN_TDATA_W'({on_offer.data, on_offer.sym, on_offer.side,
					on_offer.parent, on_offer.node});
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			decode_word(on_offer);
			n_accepted++;
			word_taken = 1'b1;
		end
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
		end else if (hold_wanted) begin
			hold_left = HOLD_CYCLES;
			hold_wanted = 1'b0;
		end
	end

	always @(negedge clk) begin
		m_tready <= (hold_left == 0) && ($urandom_range(99) >= sink_stall_pct);
	end

	always @(posedge clk) begin : symbol_monitor
		symbol_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (symbols_due.size() == 0) begin
				report_mismatch("symbol word with none outstanding", int'(m_tdata), -1);
			end else begin
				want = symbols_due.pop_front();
				if (m_tdata !== want.symbol)
					report_mismatch("symbol", int'(m_tdata), int'(want.symbol));
				if (m_tlast !== want.is_last)
					report_mismatch("last flag", int'(m_tlast), int'(want.is_last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		int w;
		arst_n = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Two-leaf tree: every bit yields a symbol, so a byte gives eight.
		set_idling(0);
		cfg_write(REG_LEAF_COUNT, 9'd2);
		cfg_write(REG_PAD_BITS, 9'd0);
		push_load(0, 2, SIDE_LEFT, 8'h00);
		push_load(1, 2, SIDE_RIGHT, 8'hFF);
		push_load(2, 2, SIDE_LEFT, 8'h5A);
		push_load(NODE_NONE, 2, SIDE_RIGHT, 8'h77);
		push_load(0, NODE_NONE, SIDE_RIGHT, 8'hA5);
		push_data(8'hFF, 1'b0);
		push_data(8'h00, 1'b1);
		push_data(8'h55, 1'b0);
		settle();
		cfg_write(REG_PAD_BITS, 9'd7);
		push_data(8'h80, 1'b1);
		push_data(8'h7F, 1'b1);
		push_data(8'h3C, 1'b0);
		settle();

		// A leaf count of zero leaves a tree whose root is its only leaf.
		cfg_write(REG_LEAF_COUNT, 9'd0);
		push_load(0, 510, SIDE_LEFT, 8'h33);
		push_data(8'hFF, 1'b0);
		push_data(8'h00, 1'b1);
		settle();

		// Three leaves: codes run across a byte boundary into a padded byte.
		cfg_write(REG_LEAF_COUNT, 9'd3);
		cfg_write(REG_PAD_BITS, 9'd3);
		push_load(0, 4, SIDE_LEFT, 8'h11);
		push_load(3, 4, SIDE_RIGHT, 8'h00);
		push_load(1, 3, SIDE_LEFT, 8'h22);
		push_load(2, 3, SIDE_RIGHT, 8'h33);
		push_data(8'hB5, 1'b0);
		push_data(8'hE0, 1'b1);
		settle();

		for (int p = 0; p < 8; p++)
			random_phase(p);

		while (n_accepted != n_queued)
			@(negedge clk);
		for (w = 0; w < 5000 && symbols_due.size() != 0; w++)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (symbols_due.size() != 0)
			report_mismatch("symbol words never produced", 0, symbols_due.size());
		if (n_errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ----- files.f -----
sv/hftw_pkg.sv
sv/hftw_ram.sv
sv/huffman_tree_walk_decoder_top.sv
verif/tb_huffman_tree_walk_decoder_top.sv
